// ----- src/tsp_pkg.sv -----
package tsp_pkg;

    localparam int ADDR_W          = 24;
    localparam int ADDR_DIGITS_MIN = 4;
    localparam int ADDR_DIGITS_MAX = 6;
    localparam int DCNT_W          = $clog2(ADDR_DIGITS_MAX + 1);
    localparam int SEGMENT_BYTES   = 512;
    localparam int SEG_W           = $clog2(SEGMENT_BYTES);
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [ADDR_W-1:0] RAM_LOW_RST    = 24'h001C00;
    localparam logic [ADDR_W-1:0] RAM_HIGH_RST   = 24'h005BFF;
    localparam logic [ADDR_W-1:0] FLASH_LOW_RST  = 24'h005C00;
    localparam logic [ADDR_W-1:0] FLASH_HIGH_RST = 24'h03FFFF;

    localparam logic [1:0] CFG_RAM_LOW    = 2'd0;
    localparam logic [1:0] CFG_RAM_HIGH   = 2'd1;
    localparam logic [1:0] CFG_FLASH_LOW  = 2'd2;
    localparam logic [1:0] CFG_FLASH_HIGH = 2'd3;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERR   = 2'd2;

    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_LQ    = 8'h71;
    localparam logic [7:0] CH_UQ    = 8'h51;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        CLS_HEX,
        CLS_AT,
        CLS_QUIT,
        CLS_CR,
        CLS_LF,
        CLS_SPACE,
        CLS_OTHER
    } t_cls;

    typedef struct packed {
        t_cls       cls;
        logic [3:0] nib;
    } t_cls_word;

    typedef enum logic [2:0] {
        ST_START,
        ST_ADDR,
        ST_NEWLINE,
        ST_BYTE,
        ST_SPACE,
        ST_AFTER_SPACE,
        ST_END,
        ST_ERROR
    } t_state;

endpackage

// ----- src/tsp_front.sv -----
module tsp_front (
    input  logic [7:0]         i_char,
    output tsp_pkg::t_cls_word o_word
);

    logic [7:0] lo_sub;
    logic [7:0] up_sub;
    logic [7:0] dg_sub;

    assign dg_sub = i_char - 8'h30;
    assign up_sub = i_char - 8'h37;
    assign lo_sub = i_char - 8'h57;

    always_comb begin
        o_word.cls = tsp_pkg::CLS_OTHER;
        o_word.nib = 4'd0;
        if (i_char >= 8'h30 && i_char <= 8'h39) begin
            o_word.cls = tsp_pkg::CLS_HEX;
            o_word.nib = dg_sub[3:0];
        end else if (i_char >= 8'h41 && i_char <= 8'h46) begin
            o_word.cls = tsp_pkg::CLS_HEX;
            o_word.nib = up_sub[3:0];
        end else if (i_char >= 8'h61 && i_char <= 8'h66) begin
            o_word.cls = tsp_pkg::CLS_HEX;
            o_word.nib = lo_sub[3:0];
        end else if (i_char == tsp_pkg::CH_AT) begin
            o_word.cls = tsp_pkg::CLS_AT;
        end else if (i_char == tsp_pkg::CH_LQ || i_char == tsp_pkg::CH_UQ) begin
            o_word.cls = tsp_pkg::CLS_QUIT;
        end else if (i_char == tsp_pkg::CH_CR) begin
            o_word.cls = tsp_pkg::CLS_CR;
        end else if (i_char == tsp_pkg::CH_LF) begin
            o_word.cls = tsp_pkg::CLS_LF;
        end else if (i_char == tsp_pkg::CH_SPACE) begin
            o_word.cls = tsp_pkg::CLS_SPACE;
        end
    end

endmodule

// ----- src/tsp_fifo.sv -----
module tsp_fifo #(
    parameter int DEPTH = tsp_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tsp_pkg::t_cls_word i_word,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output tsp_pkg::t_cls_word o_word
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    tsp_pkg::t_cls_word r_mem [DEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_cnt,  n_cnt;

    assign o_full  = (r_cnt == FULL);
    assign o_empty = (r_cnt == '0);
    assign o_word  = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = (r_wptr == LAST) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == LAST) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_word;
        end
    end

endmodule

// ----- src/tsp_back.sv -----
module tsp_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [tsp_pkg::ADDR_W-1:0]  i_cfg_data,
    input  logic                        i_empty,
    input  tsp_pkg::t_cls_word          i_word,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_kind,
    output logic [tsp_pkg::ADDR_W-1:0]  o_address,
    output logic [7:0]                  o_data,
    output logic                        o_to_flash,
    output logic                        o_erase_first
);

    localparam int AW = tsp_pkg::ADDR_W;
    localparam int DW = tsp_pkg::DCNT_W;
    localparam int SW = tsp_pkg::SEG_W;
    localparam logic [DW-1:0] DMAX = DW'(tsp_pkg::ADDR_DIGITS_MAX);
    localparam logic [DW-1:0] DMIN = DW'(tsp_pkg::ADDR_DIGITS_MIN);

    logic [AW-1:0] r_ram_low, r_ram_high, r_flash_low, r_flash_high;

    tsp_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_wa, n_wa;
    logic [DW-1:0]   r_dcnt, n_dcnt;
    logic [3:0]      r_hnib, n_hnib;
    logic            r_crlf, n_crlf;
    logic            r_style_known, n_style_known;
    logic [1:0]      r_nl_cnt, n_nl_cnt;
    logic            r_tflash, n_tflash;
    logic            r_seg_erased, n_seg_erased;
    logic            r_wide, n_wide;

    logic            r_out_valid;
    logic [1:0]      r_kind, n_kind;
    logic [AW-1:0]   r_addr, n_addr;
    logic [7:0]      r_data, n_data;
    logic            r_flash_o, n_flash_o;
    logic            r_erase_o, n_erase_o;
    logic            emit;

    logic            is_hex, is_at, is_quit, is_cr, is_lf, is_space;
    logic            nl_crlf, nl_need_met, nl_expect_ok, nl_call;
    logic [1:0]      nl_in_cnt;
    logic            in_ram, in_flash, addr_ok;
    logic [AW-1:0]   wa_inc;

    assign is_hex   = (i_word.cls == tsp_pkg::CLS_HEX);
    assign is_at    = (i_word.cls == tsp_pkg::CLS_AT);
    assign is_quit  = (i_word.cls == tsp_pkg::CLS_QUIT);
    assign is_cr    = (i_word.cls == tsp_pkg::CLS_CR);
    assign is_lf    = (i_word.cls == tsp_pkg::CLS_LF);
    assign is_space = (i_word.cls == tsp_pkg::CLS_SPACE);

    assign o_pop = !i_empty && (!r_out_valid || i_out_ready);

    // the first line end fixes the style
    assign nl_crlf      = r_style_known ? r_crlf : !is_lf;
    assign nl_in_cnt    = (r_state == tsp_pkg::ST_NEWLINE) ? r_nl_cnt : 2'd0;
    assign nl_need_met  = (r_state == tsp_pkg::ST_NEWLINE) &&
                          (r_nl_cnt >= (nl_crlf ? 2'd2 : 2'd1));
    assign nl_expect_ok = (nl_crlf && nl_in_cnt == 2'd0) ? is_cr : is_lf;

    assign in_ram   = (r_wa >= r_ram_low) && (r_wa <= r_ram_high);
    assign in_flash = (r_wa >= r_flash_low) && (r_wa <= r_flash_high);
    assign addr_ok  = (r_dcnt >= DMIN) && !r_wide && (r_wa != '0) && (in_ram || in_flash);
    assign wa_inc   = r_wa + 1'b1;

    assign nl_call = (r_state == tsp_pkg::ST_NEWLINE) ||
                     (r_state == tsp_pkg::ST_ADDR && !is_hex && addr_ok) ||
                     (r_state == tsp_pkg::ST_AFTER_SPACE && (is_cr || is_lf));

    // next state
    always_comb begin
        n_state = r_state;
        if (o_pop) begin
            unique case (r_state)
                tsp_pkg::ST_START: begin
                    n_state = is_at ? tsp_pkg::ST_ADDR : tsp_pkg::ST_ERROR;
                end
                tsp_pkg::ST_ADDR: begin
                    if (is_hex) begin
                        n_state = (r_dcnt >= DMAX) ? tsp_pkg::ST_ERROR : tsp_pkg::ST_ADDR;
                    end else if (addr_ok && nl_expect_ok) begin
                        n_state = tsp_pkg::ST_NEWLINE;
                    end else begin
                        n_state = tsp_pkg::ST_ERROR;
                    end
                end
                tsp_pkg::ST_NEWLINE: begin
                    if (nl_need_met) begin
                        if (is_at) begin
                            n_state = tsp_pkg::ST_ADDR;
                        end else if (is_quit) begin
                            n_state = tsp_pkg::ST_END;
                        end else if (is_hex) begin
                            n_state = tsp_pkg::ST_BYTE;
                        end else begin
                            n_state = tsp_pkg::ST_ERROR;
                        end
                    end else begin
                        n_state = nl_expect_ok ? tsp_pkg::ST_NEWLINE : tsp_pkg::ST_ERROR;
                    end
                end
                tsp_pkg::ST_BYTE: begin
                    n_state = is_hex ? tsp_pkg::ST_SPACE : tsp_pkg::ST_ERROR;
                end
                tsp_pkg::ST_SPACE: begin
                    n_state = is_space ? tsp_pkg::ST_AFTER_SPACE : tsp_pkg::ST_ERROR;
                end
                tsp_pkg::ST_AFTER_SPACE: begin
                    if (is_cr || is_lf) begin
                        n_state = nl_expect_ok ? tsp_pkg::ST_NEWLINE : tsp_pkg::ST_ERROR;
                    end else if (is_hex) begin
                        n_state = tsp_pkg::ST_BYTE;
                    end else begin
                        n_state = tsp_pkg::ST_ERROR;
                    end
                end
                tsp_pkg::ST_END: begin
                    n_state = tsp_pkg::ST_END;
                end
                tsp_pkg::ST_ERROR: begin
                    n_state = tsp_pkg::ST_ERROR;
                end
                default: begin
                    n_state = tsp_pkg::ST_ERROR;
                end
            endcase
        end
    end

    // outputs and working registers
    always_comb begin
        n_wa          = r_wa;
        n_dcnt        = r_dcnt;
        n_hnib        = r_hnib;
        n_crlf        = r_crlf;
        n_style_known = r_style_known;
        n_nl_cnt      = r_nl_cnt;
        n_tflash      = r_tflash;
        n_seg_erased  = r_seg_erased;
        n_wide        = r_wide;
        emit          = 1'b0;
        n_kind        = tsp_pkg::KIND_WRITE;
        n_addr        = '0;
        n_data        = 8'd0;
        n_flash_o     = 1'b0;
        n_erase_o     = 1'b0;
        if (o_pop) begin
            if (nl_call && !r_style_known) begin
                n_crlf        = !is_lf;
                n_style_known = 1'b1;
            end
            n_nl_cnt = (n_state == tsp_pkg::ST_NEWLINE) ? nl_in_cnt + 2'd1 : 2'd0;

            // a new address line clears the address accumulator
            if ((r_state == tsp_pkg::ST_START || nl_need_met) &&
                n_state == tsp_pkg::ST_ADDR) begin
                n_wa   = '0;
                n_dcnt = '0;
                n_wide = 1'b0;
            end

            if (r_state == tsp_pkg::ST_ADDR && n_state == tsp_pkg::ST_ADDR) begin
                n_wide = r_wide || (r_wa[AW-1:AW-4] != 4'd0);
                n_wa   = {r_wa[AW-5:0], i_word.nib};
                n_dcnt = r_dcnt + 1'b1;
            end

            if (r_state == tsp_pkg::ST_ADDR && !is_hex && addr_ok) begin
                n_tflash     = !in_ram;
                n_seg_erased = 1'b0;
                n_dcnt       = '0;
            end

            if (r_state != tsp_pkg::ST_BYTE && n_state == tsp_pkg::ST_BYTE) begin
                n_hnib = i_word.nib;
            end

            if (n_state == tsp_pkg::ST_ERROR) begin
                emit   = 1'b1;
                n_kind = tsp_pkg::KIND_ERR;
            end else if (n_state == tsp_pkg::ST_END) begin
                emit   = 1'b1;
                n_kind = tsp_pkg::KIND_END;
            end else if (r_state == tsp_pkg::ST_BYTE) begin
                emit      = 1'b1;
                n_kind    = tsp_pkg::KIND_WRITE;
                n_addr    = r_wa;
                n_data    = {r_hnib, i_word.nib};
                n_flash_o = r_tflash;
                n_erase_o = r_tflash && !r_seg_erased;
                n_wa      = wa_inc;
                if (r_tflash) begin
                    // drop the erased mark on a segment boundary
                    n_seg_erased = (wa_inc[SW-1:0] != '0);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_low    <= tsp_pkg::RAM_LOW_RST;
            r_ram_high   <= tsp_pkg::RAM_HIGH_RST;
            r_flash_low  <= tsp_pkg::FLASH_LOW_RST;
            r_flash_high <= tsp_pkg::FLASH_HIGH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tsp_pkg::CFG_RAM_LOW:    r_ram_low    <= i_cfg_data;
                tsp_pkg::CFG_RAM_HIGH:   r_ram_high   <= i_cfg_data;
                tsp_pkg::CFG_FLASH_LOW:  r_flash_low  <= i_cfg_data;
                tsp_pkg::CFG_FLASH_HIGH: r_flash_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= tsp_pkg::ST_START;
            r_wa          <= '0;
            r_dcnt        <= '0;
            r_hnib        <= 4'd0;
            r_crlf        <= 1'b0;
            r_style_known <= 1'b0;
            r_nl_cnt      <= 2'd0;
            r_tflash      <= 1'b1;
            r_seg_erased  <= 1'b0;
            r_wide        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_wa          <= n_wa;
            r_dcnt        <= n_dcnt;
            r_hnib        <= n_hnib;
            r_crlf        <= n_crlf;
            r_style_known <= n_style_known;
            r_nl_cnt      <= n_nl_cnt;
            r_tflash      <= n_tflash;
            r_seg_erased  <= n_seg_erased;
            r_wide        <= n_wide;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind    <= n_kind;
            r_addr    <= n_addr;
            r_data    <= n_data;
            r_flash_o <= n_flash_o;
            r_erase_o <= n_erase_o;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_address     = r_addr;
    assign o_data        = r_data;
    assign o_to_flash    = r_flash_o;
    assign o_erase_first = r_erase_o;

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == tsp_pkg::KIND_ERR) |-> r_state == tsp_pkg::ST_ERROR)
        else $error("error word shown while parser left the error state");

    a_end_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == tsp_pkg::KIND_END) |-> r_state == tsp_pkg::ST_END)
        else $error("end word shown while parser left the end state");

    a_dcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dcnt <= DMAX)
        else $error("address digit count beyond limit");

    a_write_erase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_erase_o) |-> (r_flash_o && r_kind == tsp_pkg::KIND_WRITE))
        else $error("erase flag on a word that is not a flash write");

endmodule

// ----- src/ti_txt_stream_parser.sv -----
// An accepted character is written into the queue; the back end pops it from there, and
// any result word that it yields is registered and held on the outputs until taken.
// Throughput: one character per cycle while the queue is not full; the back end retires one queued character
// per cycle whenever the output register is empty or being taken.
// Reset: i_rst_n is synchronous, active low; it empties the queue, returns the
// parser to waiting for the start marker and reloads the window registers.
module ti_txt_stream_parser #(
    parameter int QUEUE_DEPTH = tsp_pkg::QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [tsp_pkg::ADDR_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [7:0]                  i_char_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_kind,
    output logic [tsp_pkg::ADDR_W-1:0]  o_address,
    output logic [7:0]                  o_data,
    output logic                        o_to_flash,
    output logic                        o_erase_first
);

    tsp_pkg::t_cls_word front_word;
    tsp_pkg::t_cls_word queue_word;
    logic               q_full;
    logic               q_empty;
    logic               q_pop;
    logic               q_push;

    assign o_in_ready = !q_full;
    assign q_push     = i_in_valid && !q_full;

    tsp_front u_front (
        .i_char (i_char_in),
        .o_word (front_word)
    );

    tsp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_word  (front_word),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_word  (queue_word)
    );

    tsp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_empty       (q_empty),
        .i_word        (queue_word),
        .o_pop         (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_address     (o_address),
        .o_data        (o_data),
        .o_to_flash    (o_to_flash),
        .o_erase_first (o_erase_first)
    );

endmodule
